// ----- rtl/lrdm_pkg.sv -----
// lrdm_pkg: shared types and constants for the low-rank delta merge block
// word layouts, command and register codes, fixed-point format constants
// no dependencies
package lrdm_pkg;

    // fixed-point formats
    localparam int VALUE_BITS = 16;             // signed q4.12 values
    localparam int FRAC_BITS  = VALUE_BITS - 4;
    localparam int SCALE_BITS = 16;             // unsigned q8.8 scale
    localparam int SCALE_FRAC = 8;
    localparam int RND_SHIFT  = FRAC_BITS + SCALE_FRAC;
    localparam int IDX_BITS   = 10;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // commands
    localparam logic [1:0] CMD_WR_A    = 2'd0;
    localparam logic [1:0] CMD_WR_B    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // configuration registers
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANK     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_WIDTH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_ROWS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADD_BASE = 3'd4;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic [IDX_BITS-1:0]          row_index;
        logic [IDX_BITS-1:0]          col_index;
        logic signed [VALUE_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] result_value;
        logic                         saturated;
        logic                         index_error;
    } result_t;

    // sequencer to multiply-accumulate control
    typedef struct packed {
        logic clr;      // clear accumulator
        logic issue;    // memory read issued this cycle
        logic last;     // read is the last rank term
    } mac_ctl_t;

endpackage

// ----- rtl/low_rank_delta_merge_core.sv -----
// low_rank_delta_merge_core: low-rank factor stores and element-wise delta merge
// a factor write is taken in idle and lands in its store; a compute word reads each store once
// per rank term (rank = sizes in use), accumulates, then passes the post stage; with no terms
// (rank zero or index error) it goes straight to post; next word taken as the result loads
// reset: asynchronous, active low; clears control and restores config defaults, stores keep data
module low_rank_delta_merge_core #(
    parameter int MAX_RANK     = 16,
    parameter int MAX_IN_WIDTH = 1024,
    parameter int MAX_OUT_ROWS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lrdm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lrdm_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  lrdm_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lrdm_pkg::result_t                   result
);
    import lrdm_pkg::*;

    localparam int RK_W    = $clog2(MAX_RANK + 1);
    localparam int KW      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int WD_W    = $clog2(MAX_IN_WIDTH + 1);
    localparam int RW_W    = $clog2(MAX_OUT_ROWS + 1);
    localparam int A_DEPTH = MAX_RANK * MAX_IN_WIDTH;
    localparam int B_DEPTH = MAX_OUT_ROWS * MAX_RANK;
    localparam int A_AW    = $clog2(A_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);
    localparam int ACC_W   = 2 * VALUE_BITS + $clog2(MAX_RANK + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // takes words, factor writes land here
    localparam logic [2:0] S_RUN   = 3'd1;  // one read of each store per rank term
    localparam logic [2:0] S_START = 3'd2;  // no terms to sum or index error, kick post stage
    localparam logic [2:0] S_DRAIN = 3'd3;  // wait for last product in accumulator
    localparam logic [2:0] S_POST  = 3'd4;  // wait for post result and free output

    // configuration registers
    logic [4:0]            rank_reg;
    logic [10:0]           in_width_reg;
    logic [10:0]           out_rows_reg;
    logic [SCALE_BITS-1:0] scale_reg;
    logic                  add_base_reg;

    // sequencer
    logic [2:0]                   state_reg, state_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [IDX_BITS-1:0]          row_reg, col_reg;
    logic signed [VALUE_BITS-1:0] base_reg;
    logic                         err_reg;
    result_t                      result_reg, result_next;
    logic                         result_valid_reg, result_valid_next;

    logic [RK_W-1:0] rk_use;
    logic [WD_W-1:0] wd_use;
    logic [RW_W-1:0] rw_use;
    logic            item_acc, is_compute, cmp_err, last_k;
    logic            a_we, b_we;
    logic [A_AW-1:0] a_addr;
    logic [B_AW-1:0] b_addr;
    logic signed [VALUE_BITS-1:0] a_rdata, b_rdata;
    mac_ctl_t        mac_ctl;
    logic signed [ACC_W-1:0] acc;
    logic            mac_done;
    logic            post_start, post_vld, post_take, out_free;
    result_t         post_res;

    // sizes in use, clipped to the store dimensions
    always_comb
    begin
        rk_use = (32'(rank_reg) > MAX_RANK) ? RK_W'(MAX_RANK) : RK_W'(rank_reg);
        wd_use = (32'(in_width_reg) > MAX_IN_WIDTH) ? WD_W'(MAX_IN_WIDTH) : WD_W'(in_width_reg);
        rw_use = (32'(out_rows_reg) > MAX_OUT_ROWS) ? RW_W'(MAX_OUT_ROWS) : RW_W'(out_rows_reg);
    end

    assign item_ready = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign is_compute = (item.cmd == CMD_COMPUTE);
    assign cmp_err    = (32'(item.row_index) >= 32'(rw_use))
                     || (32'(item.col_index) >= 32'(wd_use));
    assign last_k     = (RK_W'(k_reg) == (rk_use - RK_W'(1)));

    // out of range factor writes are dropped
    assign a_we = item_acc && (item.cmd == CMD_WR_A)
               && (32'(item.row_index) < 32'(rk_use))
               && (32'(item.col_index) < 32'(wd_use));
    assign b_we = item_acc && (item.cmd == CMD_WR_B)
               && (32'(item.row_index) < 32'(rw_use))
               && (32'(item.col_index) < 32'(rk_use));

    // a is row-major by rank term, b row-major by output row
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            a_addr = A_AW'(32'(item.row_index) * MAX_IN_WIDTH + 32'(item.col_index));
            b_addr = B_AW'(32'(item.row_index) * MAX_RANK + 32'(item.col_index));
        end
        else
        begin
            a_addr = A_AW'(32'(k_reg) * MAX_IN_WIDTH + 32'(col_reg));
            b_addr = B_AW'(32'(row_reg) * MAX_RANK + 32'(k_reg));
        end
    end

    lrdm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (A_DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .addr  (a_addr),
        .wdata (item.value),
        .rdata (a_rdata)
    );

    lrdm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (B_DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .addr  (b_addr),
        .wdata (item.value),
        .rdata (b_rdata)
    );

    always_comb
    begin
        mac_ctl.clr   = item_acc && is_compute;
        mac_ctl.issue = (state_reg == S_RUN);
        mac_ctl.last  = last_k;
    end

    lrdm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .acc    (acc),
        .done   (mac_done)
    );

    lrdm_post #(
        .ACC_W (ACC_W)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (post_start),
        .acc      (acc),
        .scale    (scale_reg),
        .add_base (add_base_reg),
        .base     (base_reg),
        .take     (post_take),
        .vld      (post_vld),
        .res      (post_res)
    );

    // output register parts the result side from the sequencer
    assign out_free  = !result_valid_reg || result_ready;
    assign post_take = (state_reg == S_POST) && post_vld && out_free;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        post_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (item_acc && is_compute)
                begin
                    // index errors and rank zero skip the reads
                    if (cmp_err || (rk_use == '0))
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                k_next = k_reg + KW'(1);
                if (last_k)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_START:
            begin
                post_start = 1'b1;
                state_next = S_POST;
            end
            S_DRAIN:
            begin
                if (mac_done)
                begin
                    post_start = 1'b1;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (post_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (post_take)
        begin
            result_valid_next = 1'b1;
            if (err_reg)
            begin
                result_next.result_value = '0;
                result_next.saturated    = 1'b0;
                result_next.index_error  = 1'b1;
            end
            else
            begin
                result_next = post_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
            rank_reg         <= 5'd8;
            in_width_reg     <= 11'd1024;
            out_rows_reg     <= 11'd1024;
            scale_reg        <= 16'd256;
            add_base_reg     <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_RANK:     rank_reg     <= cfg_wr_data[4:0];
                    CFG_IN_WIDTH: in_width_reg <= cfg_wr_data[10:0];
                    CFG_OUT_ROWS: out_rows_reg <= cfg_wr_data[10:0];
                    CFG_SCALE:    scale_reg    <= cfg_wr_data;
                    CFG_ADD_BASE: add_base_reg <= cfg_wr_data[0];
                    default:      ;
                endcase
            end
        end
    end

    // compute word payload, captured on acceptance
    always_ff @(posedge clk)
    begin
        if (item_acc && is_compute)
        begin
            row_reg  <= item.row_index;
            col_reg  <= item.col_index;
            base_reg <= item.value;
            err_reg  <= cmp_err;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/lrdm_ram.sv -----
// lrdm_ram: generic single-port synchronous ram, registered read
// no dependencies
module lrdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lrdm_mac.sv -----
// lrdm_mac: multiply-accumulate pipeline over factor words read from the stores
// depends on lrdm_pkg
module lrdm_mac #(
    parameter int ACC_W = 37
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  lrdm_pkg::mac_ctl_t                       ctl,
    input  logic signed [lrdm_pkg::VALUE_BITS-1:0]   a_data,
    input  logic signed [lrdm_pkg::VALUE_BITS-1:0]   b_data,
    output logic signed [ACC_W-1:0]                  acc,
    output logic                                     done
);
    import lrdm_pkg::*;

    localparam int PR_W = 2 * VALUE_BITS;

    logic                   rd_vld_reg, rd_last_reg;
    logic                   mul_vld_reg, mul_last_reg;
    logic                   done_reg;
    logic signed [PR_W-1:0] prod_reg, prod_next;
    logic signed [PR_W-1:0] a_ext, b_ext;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        a_ext     = {{VALUE_BITS{a_data[VALUE_BITS-1]}}, a_data};
        b_ext     = {{VALUE_BITS{b_data[VALUE_BITS-1]}}, b_data};
        prod_next = a_ext * b_ext;
        acc_next  = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (mul_vld_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PR_W){prod_reg[PR_W-1]}}, prod_reg};
        end
    end

    // flags follow the read data through the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            mul_vld_reg  <= 1'b0;
            mul_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= ctl.issue;
            rd_last_reg  <= ctl.issue && ctl.last;
            mul_vld_reg  <= rd_vld_reg;
            mul_last_reg <= rd_last_reg;
            done_reg     <= mul_vld_reg && mul_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ----- rtl/lrdm_post.sv -----
// lrdm_post: scale, round, optional base add and saturation of the accumulated sum
// depends on lrdm_pkg; three registered stages, result held until taken
module lrdm_post #(
    parameter int ACC_W = 37
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [ACC_W-1:0]                acc,
    input  logic [lrdm_pkg::SCALE_BITS-1:0]        scale,
    input  logic                                   add_base,
    input  logic signed [lrdm_pkg::VALUE_BITS-1:0] base,
    input  logic                                   take,
    output logic                                   vld,
    output lrdm_pkg::result_t                      res
);
    import lrdm_pkg::*;

    localparam int LO = ACC_W / 2;
    localparam int HI = ACC_W - LO;
    localparam int LW = LO + SCALE_BITS;
    localparam int HW = HI + SCALE_BITS + 1;
    localparam int PW = ACC_W + SCALE_BITS + 1;
    localparam int RW = PW - RND_SHIFT;
    localparam int SW = RW + 1;

    localparam logic [PW-1:0] RND_HALF =
        {{(PW-RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT-1){1'b0}}};
    localparam logic signed [SW-1:0] SUM_MAX =
        {{(SW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN =
        {{(SW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

    logic                 s1_vld_reg, s2_vld_reg, res_vld_reg;
    logic [LW-1:0]        plo_reg, plo_next, lo_ext, sc_lo;
    logic signed [HW-1:0] phi_reg, phi_next, hi_ext, sc_hi;
    logic [PW-1:0]        full;
    logic signed [RW-1:0] rnd_reg, rnd_next;
    logic signed [SW-1:0] sum, base_ext;
    result_t              res_reg, res_next;

    // stage 1: split product, low half unsigned, high half signed
    always_comb
    begin
        lo_ext   = {{SCALE_BITS{1'b0}}, acc[LO-1:0]};
        sc_lo    = {{LO{1'b0}}, scale};
        plo_next = lo_ext * sc_lo;
        hi_ext   = {{(SCALE_BITS+1){acc[ACC_W-1]}}, acc[ACC_W-1:LO]};
        sc_hi    = {{HI{1'b0}}, 1'b0, scale};
        phi_next = hi_ext * sc_hi;
    end

    // stage 2: recombine, add half an lsb, floor
    always_comb
    begin
        full     = {phi_reg, {LO{1'b0}}} + {{(PW-LW){1'b0}}, plo_reg} + RND_HALF;
        rnd_next = $signed(full[PW-1:RND_SHIFT]);
    end

    // stage 3: base add and clip
    always_comb
    begin
        base_ext = '0;
        if (add_base)
        begin
            base_ext = {{(SW-VALUE_BITS){base[VALUE_BITS-1]}}, base};
        end
        sum = {rnd_reg[RW-1], rnd_reg} + base_ext;
        res_next.index_error = 1'b0;
        if (sum > SUM_MAX)
        begin
            res_next.result_value = VALUE_MAX;
            res_next.saturated    = 1'b1;
        end
        else if (sum < SUM_MIN)
        begin
            res_next.result_value = VALUE_MIN;
            res_next.saturated    = 1'b1;
        end
        else
        begin
            res_next.result_value = sum[VALUE_BITS-1:0];
            res_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            if (s2_vld_reg)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (take)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (s1_vld_reg)
        begin
            rnd_reg <= rnd_next;
        end
        if (s2_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign vld = res_vld_reg;
    assign res = res_reg;

endmodule

// ----- rtl/lrdm_check.sv -----
// lrdm_check: port-level assertions for low_rank_delta_merge_core
// depends on lrdm_pkg; bound to the top level at the end of this file
module lrdm_check (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_wr_en,
    input logic [lrdm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input logic [lrdm_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input logic                                item_valid,
    input logic                                item_ready,
    input lrdm_pkg::item_t                     item,
    input logic                                result_valid,
    input logic                                result_ready,
    input lrdm_pkg::result_t                   result
);
    import lrdm_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed or dropped while stalled");

    // nothing comes out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

    // a compute word occupies the sequencer
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.cmd == CMD_COMPUTE) |=> !item_ready)
        else $error("word taken while a compute is in flight");

    // factor writes and unused commands leave the input ready
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.cmd != CMD_COMPUTE) |=> item_ready)
        else $error("write word stalled the input");

    // an idle block with no compute word coming gives no result
    a_cfg_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && item_ready && !(item_valid && item.cmd == CMD_COMPUTE)
        |=> !result_valid)
        else $error("result word without a compute word");

endmodule

bind low_rank_delta_merge_core lrdm_check u_lrdm_check (.*);

// ----- tb/sv/lrdm_merge_checker.sv -----
// lrdm_merge_checker: watches the word and result channels of the low-rank delta merge core,
// predicts each result from its own copy of the factor stores and registers, and compares
// depends on lrdm_pkg
module lrdm_merge_checker #(
    parameter int MAX_RANK     = 16,
    parameter int MAX_IN_WIDTH = 1024,
    parameter int MAX_OUT_ROWS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lrdm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lrdm_pkg::CFG_DATA_BITS-1:0] cfg_wr_data,
    input  logic                               item_valid,
    input  logic                               item_ready,
    input  lrdm_pkg::item_t                    item,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  lrdm_pkg::result_t                  result,
    output int                                 fail_count,
    output int                                 results_owed
);
    import lrdm_pkg::*;

    localparam longint HI_CLIP = longint'($signed(VALUE_MAX));
    localparam longint LO_CLIP = longint'($signed(VALUE_MIN));

    logic signed [VALUE_BITS-1:0] a_factor [MAX_RANK*MAX_IN_WIDTH];
    logic signed [VALUE_BITS-1:0] b_factor [MAX_OUT_ROWS*MAX_RANK];

    logic [4:0]  rank_reg;
    logic [10:0] width_reg;
    logic [10:0] rows_reg;
    logic [15:0] scale_reg;
    logic        base_reg;

    result_t merged_q[$];

    // applies one word to the shadow stores; returns 1 with the predicted result for a compute
    function automatic bit merge_word(input item_t w, output result_t r);
        int unsigned rk;
        int unsigned wd;
        int unsigned rw;
        longint      acc;
        longint      merged;
        rk  = (rank_reg > MAX_RANK) ? MAX_RANK : rank_reg;
        wd  = (width_reg > MAX_IN_WIDTH) ? MAX_IN_WIDTH : width_reg;
        rw  = (rows_reg > MAX_OUT_ROWS) ? MAX_OUT_ROWS : rows_reg;
        r   = '0;
        acc = 0;
        case (w.cmd)
            CMD_WR_A:
            begin
                if (w.row_index < rk && w.col_index < wd)
                    a_factor[w.row_index*MAX_IN_WIDTH + w.col_index] = w.value;
                return 1'b0;
            end
            CMD_WR_B:
            begin
                if (w.row_index < rw && w.col_index < rk)
                    b_factor[w.row_index*MAX_RANK + w.col_index] = w.value;
                return 1'b0;
            end
            CMD_COMPUTE:
            begin
                if (w.row_index >= rw || w.col_index >= wd)
                begin
                    r.index_error = 1'b1;
                    return 1'b1;
                end
                for (int k = 0; k < rk; k++)
                    acc += longint'(b_factor[w.row_index*MAX_RANK + k])
                         * longint'(a_factor[k*MAX_IN_WIDTH + w.col_index]);
                // round half up back to the value format
                merged = (acc * longint'(scale_reg) + (longint'(1) <<< (RND_SHIFT - 1)))
                         >>> RND_SHIFT;
                if (base_reg)
                    merged += longint'(w.value);
                if (merged > HI_CLIP)
                begin
                    merged      = HI_CLIP;
                    r.saturated = 1'b1;
                end
                else if (merged < LO_CLIP)
                begin
                    merged      = LO_CLIP;
                    r.saturated = 1'b1;
                end
                r.result_value = merged[VALUE_BITS-1:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            rank_reg   = 5'd8;
            width_reg  = 11'd1024;
            rows_reg   = 11'd1024;
            scale_reg  = 16'd256;
            base_reg   = 1'b1;
            fail_count = 0;
            merged_q.delete();
            results_owed <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (merged_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result: expected none, actual %0d sat %0b err %0b",
                             $time, result.result_value, result.saturated, result.index_error);
                end
                else
                begin
                    want = merged_q.pop_front();
                    if (result.result_value !== want.result_value)
                    begin
                        fail_count++;
                        $display("%0t result_value mismatch: expected %0d, actual %0d",
                                 $time, want.result_value, result.result_value);
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        fail_count++;
                        $display("%0t saturated mismatch: expected %0b, actual %0b",
                                 $time, want.saturated, result.saturated);
                    end
                    if (result.index_error !== want.index_error)
                    begin
                        fail_count++;
                        $display("%0t index_error mismatch: expected %0b, actual %0b",
                                 $time, want.index_error, result.index_error);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_RANK:     rank_reg  = cfg_wr_data[4:0];
                    CFG_IN_WIDTH: width_reg = cfg_wr_data[10:0];
                    CFG_OUT_ROWS: rows_reg  = cfg_wr_data[10:0];
                    CFG_SCALE:    scale_reg = cfg_wr_data[15:0];
                    CFG_ADD_BASE: base_reg  = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready && merge_word(item, fresh))
                merged_q.insert(merged_q.size(), fresh);
            results_owed <= merged_q.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: top of the low-rank delta merge core test; makes words, config writes and
// result back-pressure, and gives the verdict from the checker's failure count
// depends on lrdm_pkg, low_rank_delta_merge_core and lrdm_merge_checker
module testbench;
    import lrdm_pkg::*;

    localparam int N_RANK = 16;
    localparam int N_COLS = 1024;
    localparam int N_ROWS = 1024;

    // code the block leaves unused; such a word must vanish without a result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int POOL            = 6;
    localparam int N_PHASES        = 9;
    localparam int WORDS_PER_PHASE = 150;
    // longest compute is at rank 16; leave some margin past that
    localparam int SETTLE_CYCLES   = 32;
    localparam int LONG_HOLD_AFTER = 40;
    localparam int LONG_HOLD       = 300;

    logic    clk;
    logic    rst_n;
    logic    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    int fail_count;
    int results_owed;

    // chance of a stall burst is 1 in idle_odds per step; 0 means steady flow
    int idle_odds = 4;

    // clamped sizes as last written, used to keep compute words off unwritten entries
    int lim_rank  = 8;
    int lim_width = N_COLS;
    int lim_rows  = N_ROWS;

    // which factor entries hold data; a compute may only read marked entries
    bit a_loaded [N_RANK*N_COLS];
    bit b_loaded [N_ROWS*N_RANK];

    // rows and columns whose factors are loaded for every rank term
    int pool_rows [POOL];
    int pool_cols [POOL];

    low_rank_delta_merge_core #(
        .MAX_RANK     (N_RANK),
        .MAX_IN_WIDTH (N_COLS),
        .MAX_OUT_ROWS (N_ROWS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    lrdm_merge_checker #(
        .MAX_RANK     (N_RANK),
        .MAX_IN_WIDTH (N_COLS),
        .MAX_OUT_ROWS (N_ROWS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // mostly full-scale values, with the two extremes now and then
    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff;
            1:       return -32768;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // a compute is safe when it errors out or every factor it reads has been loaded
    function automatic bit compute_safe(input int row, input int col);
        if (row >= lim_rows || col >= lim_width)
            return 1'b1;
        for (int k = 0; k < lim_rank; k++)
            if (!b_loaded[row*N_RANK + k] || !a_loaded[k*N_COLS + col])
                return 1'b0;
        return 1'b1;
    endfunction

    // offers one word, at times after a random gap, and returns at the edge that takes it
    task automatic send_word(input logic [1:0] op, input int row, input int col, input int val);
        item_t w;
        w.cmd       = op;
        w.row_index = row[IDX_BITS-1:0];
        w.col_index = col[IDX_BITS-1:0];
        w.value     = val[VALUE_BITS-1:0];
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        // out of range writes are dropped by the block, so only in-range ones count as loaded
        if (op == CMD_WR_A && row < lim_rank && col < lim_width)
            a_loaded[row*N_COLS + col] = 1'b1;
        if (op == CMD_WR_B && row < lim_rows && col < lim_rank)
            b_loaded[row*N_RANK + col] = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data[CFG_DATA_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic apply_settings(input int rank, input int width, input int rows,
                                  input int scale, input int add);
        write_reg(CFG_RANK, rank);
        write_reg(CFG_IN_WIDTH, width);
        write_reg(CFG_OUT_ROWS, rows);
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_ADD_BASE, add);
        cfg_wr_en <= 1'b0;
        lim_rank  = (rank > N_RANK) ? N_RANK : rank;
        lim_width = (width > N_COLS) ? N_COLS : width;
        lim_rows  = (rows > N_ROWS) ? N_ROWS : rows;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    // drained, and a trailing factor write has surely landed too
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random word: factor writes (some out of range), a little noise, mostly computes
    task automatic random_word();
        int pick;
        int row;
        int col;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, N_RANK - 1);
            col = ($urandom_range(0, 1) == 0) ? pool_cols[$urandom_range(0, POOL - 1)]
                                              : $urandom_range(0, 1023);
            send_word(CMD_WR_A, row, col, pick_value());
        end
        else if (pick < 40)
        begin
            row = ($urandom_range(0, 1) == 0) ? pool_rows[$urandom_range(0, POOL - 1)]
                                              : $urandom_range(0, 1023);
            col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, N_RANK - 1);
            send_word(CMD_WR_B, row, col, pick_value());
        end
        else if (pick < 42)
            send_word(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023), pick_value());
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                row = $urandom_range(0, 1023);
                col = $urandom_range(0, 1023);
            end
            else
            begin
                row = pool_rows[$urandom_range(0, POOL - 1)];
                col = pool_cols[$urandom_range(0, POOL - 1)];
            end
            // fall back to the loaded pool rather than read an empty entry
            if (!compute_safe(row, col))
            begin
                row = pool_rows[$urandom_range(0, POOL - 1)];
                col = pool_cols[$urandom_range(0, POOL - 1)];
            end
            send_word(CMD_COMPUTE, row, col, pick_value());
        end
    endtask

    // result side: random stall bursts, and one long hold-off once LONG_HOLD_AFTER results are in,
    // so the block backs up and refuses words while the sender keeps offering
    initial
    begin : result_drain
        int  accepted;
        bit  held;
        accepted = 0;
        held     = 1'b0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                accepted++;
            if (!held && accepted >= LONG_HOLD_AFTER)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge clk);
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        item_valid  = 1'b0;
        item        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rank one: extreme factors, both saturation directions, merge clipping once
        apply_settings(1, 1024, 1024, 256, 1);
        send_word(CMD_WR_A, 0, 0, 32'sh7fff);
        send_word(CMD_WR_B, 0, 0, 32'sh7fff);
        send_word(CMD_COMPUTE, 0, 0, 32'sh7fff);
        send_word(CMD_WR_A, 0, 1023, -32768);
        send_word(CMD_WR_B, 1023, 0, -32768);
        send_word(CMD_COMPUTE, 1023, 1023, -32768);
        send_word(CMD_COMPUTE, 0, 1023, -32768);
        // writes past the rank in use are dropped
        send_word(CMD_WR_A, 5, 3, 32'sh1234);
        send_word(CMD_WR_B, 3, 1, 32'sh0777);
        send_word(CMD_UNUSED, 1023, 1023, -1);
        quiesce();

        // zero sizes: every compute is an index error
        apply_settings(0, 0, 0, 65535, 0);
        send_word(CMD_COMPUTE, 1023, 1023, 32'sh7fff);
        send_word(CMD_COMPUTE, 0, 0, -32768);
        quiesce();

        // zero rank: delta is zero, base passes through untouched
        apply_settings(0, 1024, 1024, 65535, 1);
        send_word(CMD_COMPUTE, 1023, 0, -32768);
        send_word(CMD_COMPUTE, 0, 1023, 32'sh7fff);
        quiesce();

        // oversized registers clamp to the maxima; full scale in delta-only mode
        apply_settings(1, 2047, 2047, 65535, 0);
        send_word(CMD_COMPUTE, 0, 0, 0);
        send_word(CMD_COMPUTE, 1023, 1023, 0);
        quiesce();

        // one row, one column in use: neighbors just past the edge error out
        apply_settings(2, 1, 1, 1, 0);
        send_word(CMD_COMPUTE, 1, 0, 1);
        send_word(CMD_COMPUTE, 0, 1, 1);
        quiesce();

        // load a pool of rows and columns for all rank terms at full size
        apply_settings(N_RANK, N_COLS, N_ROWS, 256, 1);
        pool_rows[0] = 0;
        pool_rows[1] = N_ROWS - 1;
        pool_cols[0] = 0;
        pool_cols[1] = N_COLS - 1;
        for (int p = 2; p < POOL; p++)
        begin
            pool_rows[p] = $urandom_range(1, N_ROWS - 2);
            pool_cols[p] = $urandom_range(1, N_COLS - 2);
        end
        for (int p = 0; p < POOL; p++)
            for (int k = 0; k < N_RANK; k++)
            begin
                send_word(CMD_WR_B, pool_rows[p], k, pick_value());
                send_word(CMD_WR_A, k, pool_cols[p], pick_value());
            end
        quiesce();

        // random phases, each under its own settings; the last one runs with no idling
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            idle_odds = (ph == N_PHASES - 1) ? 0 : ((ph % 2) != 0) ? 12 : 3;
            case (ph)
                0: apply_settings(8, 1024, 1024, 256, 1);
                1: apply_settings(16, 1024, 1024, 65535, 1);
                2: apply_settings(31, 2047, 2047, 0, 0);
                3: apply_settings(1, 1, 1, 1, 0);
                4: apply_settings(0, 512, 512, 128, 1);
                N_PHASES - 1: apply_settings(16, 1024, 1024, $urandom_range(0, 65535), 1);
                default: apply_settings($urandom_range(0, 31), $urandom_range(1, 1024),
                                        $urandom_range(1, 1024), $urandom_range(0, 65535),
                                        $urandom_range(0, 1));
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // sender pauses mid-phase until the block has emptied out
                if (ph == 2 && n == WORDS_PER_PHASE / 2)
                    wait_drained();
                random_word();
            end
            quiesce();
        end

        if (fail_count == 0 && results_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
